FILE: sv/ascii_line_deframer_top_defines.svh
// Assertion macros for the ASCII line deframer.
`ifndef ASCII_LINE_DEFRAMER_TOP_DEFINES_SVH
`define ASCII_LINE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ALD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define ALD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ald_pkg.sv
// Shared types and constants for the ASCII line deframer.
`timescale 1ns / 1ps

package ald_pkg;

  localparam int LINE_LIMIT  = 4096;
  localparam int STORE_BYTES = 8192;
  localparam int LINE_SLOTS  = 16;

  localparam int PTR_W  = $clog2(STORE_BYTES);
  localparam int LEN_W  = $clog2(LINE_LIMIT) + 1;
  localparam int HELD_W = $clog2(STORE_BYTES) + 1;
  localparam int SLOT_W = $clog2(LINE_SLOTS);
  localparam int CNT_W  = $clog2(LINE_SLOTS) + 1;
  localparam int CFG_W  = 13;

  localparam logic [7:0] NL_LF   = 8'h0A;
  localparam logic [7:0] NL_CR   = 8'h0D;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DONE    = 3'd1,
    EV_TRUNC   = 3'd2,
    EV_INVALID = 3'd3,
    EV_FULL    = 3'd4
  } event_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Port request into the byte store.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } store_req_t;

endpackage

FILE: sv/ald_byte_store.sv
// Byte ring storage: one write port, one registered read port.
`timescale 1ns / 1ps

module ald_byte_store (
  input  logic                  clk,
  input  ald_pkg::store_req_t   req,
  output logic [7:0]            rdata
);

  logic [7:0] mem [ald_pkg::STORE_BYTES];

  // Write the appended byte.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register the read data.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: sv/ascii_line_deframer_top.sv
// Top level of the ASCII line deframer: control, length queue and result register.
`timescale 1ns / 1ps
`include "ascii_line_deframer_top_defines.svh"

// Byte-serial line deframer with resync.
// Input: a request (in_operation, in_data_byte) is taken at a clock edge with
//   start high and busy low. Operations: push a received byte, read the next
//   byte of the oldest stored line, discard the unfinished line, or no-op.
// Config: cfg_we/cfg_wdata write max_line_length (reset 4096), clamped
//   to 1..4096 in use. Write it only while no request is in flight.
// Output: each request gives exactly one result, shown for one cycle with
//   out_strobe high; the receiver cannot stall and must take it then.
// Timing: the edge that accepts a request issues the registered reads of the
//   byte ring and the length queue; busy is high for the following update
//   cycle, whose edge writes the memories back and loads the result register.
//   out_strobe is high in the cycle after that, and a new request may be
//   accepted in that same cycle; no request is taken while busy is high.
// Reset (synchronous, rst_n low): pointers, counts and resync flag clear, the
//   line store is empty, no result is pending. Memory contents are not
//   cleared; only committed entries are ever read.

module ascii_line_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic [7:0]                in_data_byte,
  input  logic                      cfg_we,
  input  logic [ald_pkg::CFG_W-1:0] cfg_wdata,
  output logic                      out_strobe,
  output logic                      out_read_valid,
  output logic [7:0]                out_read_byte,
  output logic                      out_last_of_line,
  output logic [4:0]                out_lines_waiting,
  output logic [2:0]                out_event_res
);

  localparam int PW = ald_pkg::PTR_W;
  localparam int LW = ald_pkg::LEN_W;
  localparam int HW = ald_pkg::HELD_W;
  localparam int SW = ald_pkg::SLOT_W;
  localparam int CW = ald_pkg::CNT_W;

  ald_pkg::state_t state_r, state_nxt;
  logic            accept;

  // Request stage
  ald_pkg::op_t    op_r;
  logic [7:0]      byte_r;

  // Block state
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] cp_r, cp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] off_r, off_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic          resync_r, resync_nxt;
  logic [ald_pkg::CFG_W-1:0] max_len_r;

  // Length queue memory
  logic [LW-1:0] len_mem [ald_pkg::LINE_SLOTS];
  logic [LW-1:0] len_rdata;
  logic          len_we;

  ald_pkg::store_req_t store_req;
  logic [7:0]          store_rdata;

  // Datapath results
  logic             res_valid, res_last;
  logic [7:0]       res_byte;
  ald_pkg::event_t  res_ev;
  logic [LW-1:0]    lim;
  logic             is_nl, is_print;
  logic             do_drop, do_commit;
  logic [LW-1:0]    commit_len;
  logic [PW-1:0]    cp_adv;
  logic [LW-1:0]    off_inc;
  logic             slots_full;

  ald_byte_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ald_pkg::ST_IDLE: if (start) state_nxt = ald_pkg::ST_EXEC;
      ald_pkg::ST_EXEC: state_nxt = ald_pkg::ST_IDLE;
      default:          state_nxt = ald_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy   = 1'b0;
    accept = 1'b0;
    case (state_r)
      ald_pkg::ST_IDLE: accept = start;
      ald_pkg::ST_EXEC: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ald_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= ald_pkg::op_t'(in_operation);
      byte_r <= in_data_byte;
    end
  end

  // Hold the length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ald_pkg::CFG_W'(ald_pkg::LINE_LIMIT);
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // Clamp the limit to 1..LINE_LIMIT
  always_comb begin
    if (max_len_r == '0) begin
      lim = LW'(1);
    end else if (LW'(max_len_r) > LW'(ald_pkg::LINE_LIMIT)) begin
      lim = LW'(ald_pkg::LINE_LIMIT);
    end else begin
      lim = LW'(max_len_r);
    end
  end

  assign is_nl      = byte_r inside {ald_pkg::NL_LF, ald_pkg::NL_CR};
  assign is_print   = byte_r inside {[ald_pkg::PRINT_LO:ald_pkg::PRINT_HI]};
  assign slots_full = (count_r == CW'(ald_pkg::LINE_SLOTS));
  assign off_inc    = off_r + LW'(1);

  // Decide the operation: flags for drop and commit, plus read and append
  always_comb begin
    do_drop    = 1'b0;
    do_commit  = 1'b0;
    commit_len = cur_r;
    res_valid  = 1'b0;
    res_byte   = '0;
    res_last   = 1'b0;
    res_ev     = ald_pkg::EV_NONE;
    resync_nxt = resync_r;
    rp_nxt     = rp_r;
    off_nxt    = off_r;
    head_nxt   = head_r;
    store_req.we    = 1'b0;
    store_req.waddr = wp_r;
    store_req.wdata = byte_r;
    store_req.re    = accept;
    store_req.raddr = rp_r;
    case (op_r)
      ald_pkg::OP_PUSH: begin
        if (resync_r) begin
          // skip until a newline ends the resync
          if (is_nl) resync_nxt = 1'b0;
        end else if (!is_nl && !is_print) begin
          do_drop = 1'b1;
          res_ev  = ald_pkg::EV_INVALID;
        end else if ((is_nl && cur_r > lim) || (!is_nl && cur_r >= lim)) begin
          // truncate to the limit and resync, or drop the line if no length slot is free
          if (slots_full) begin
            do_drop = 1'b1;
            res_ev  = ald_pkg::EV_FULL;
          end else begin
            do_commit  = 1'b1;
            commit_len = lim;
            resync_nxt = 1'b1;
            res_ev     = ald_pkg::EV_TRUNC;
          end
        end else if (is_nl) begin
          if (cur_r != '0) begin
            if (slots_full) begin
              do_drop = 1'b1;
              res_ev  = ald_pkg::EV_FULL;
            end else begin
              do_commit = 1'b1;
              res_ev    = ald_pkg::EV_DONE;
            end
          end
        end else if (held_r >= HW'(ald_pkg::STORE_BYTES)) begin
          do_drop = 1'b1;
          res_ev  = ald_pkg::EV_FULL;
        end else begin
          store_req.we = busy;
        end
      end
      ald_pkg::OP_READ: begin
        if (count_r != '0) begin
          res_valid = 1'b1;
          res_byte  = store_rdata;
          rp_nxt    = rp_r + PW'(1);
          if (off_inc >= len_rdata) begin
            res_last = 1'b1;
            off_nxt  = '0;
            head_nxt = head_r + SW'(1);
          end else begin
            off_nxt  = off_inc;
          end
        end
      end
      ald_pkg::OP_DISCARD: do_drop = 1'b1;
      default: ;
    endcase
    if (do_drop) resync_nxt = 1'b1;
  end

  assign cp_adv = cp_r + PW'(commit_len);

  // Apply commit, drop, append and read to the pointers and counters
  always_comb begin
    wp_nxt    = wp_r;
    cp_nxt    = cp_r;
    cur_nxt   = cur_r;
    held_nxt  = held_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    len_we    = 1'b0;
    if (do_commit) begin
      len_we    = busy;
      tail_nxt  = tail_r + SW'(1);
      count_nxt = count_r + CW'(1);
      held_nxt  = held_r - HW'(cur_r - commit_len);
      cp_nxt    = cp_adv;
      wp_nxt    = cp_adv;
      cur_nxt   = '0;
    end else if (do_drop) begin
      held_nxt = held_r - HW'(cur_r);
      cur_nxt  = '0;
      wp_nxt   = cp_r;
    end else if (store_req.we) begin
      wp_nxt   = wp_r + PW'(1);
      held_nxt = held_r + HW'(1);
      cur_nxt  = cur_r + LW'(1);
    end else if (res_valid) begin
      held_nxt = held_r - HW'(1);
      if (res_last) count_nxt = count_r - CW'(1);
    end
  end

  // Length queue: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= commit_len;
    end
    if (accept) begin
      len_rdata <= len_mem[head_r];
    end
  end

  // Update the block state at the end of the update cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      cp_r     <= '0;
      rp_r     <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      cur_r    <= '0;
      off_r    <= '0;
      held_r   <= '0;
      resync_r <= 1'b0;
    end else if (busy) begin
      wp_r     <= wp_nxt;
      cp_r     <= cp_nxt;
      rp_r     <= rp_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      cur_r    <= cur_nxt;
      off_r    <= off_nxt;
      held_r   <= held_nxt;
      resync_r <= resync_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_read_valid    <= res_valid;
      out_read_byte     <= res_byte;
      out_last_of_line  <= res_last;
      out_lines_waiting <= 5'(count_nxt);
      out_event_res     <= res_ev;
    end
  end

  // Checks
  `ALD_ASSERT_NEXT(a_accept_exec, start && !busy, busy && out_strobe == 1'b0, "accept did not enter update")
  `ALD_ASSERT_NEXT(a_exec_result, busy, out_strobe && !busy, "update gave no single result")
  `ALD_ASSERT_NOW(a_read_quiet, out_strobe && !out_read_valid, out_read_byte == 8'd0 && out_last_of_line == 1'b0, "idle read carries data")
  `ALD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(ald_pkg::LINE_SLOTS) && held_r <= HW'(ald_pkg::STORE_BYTES), "line store over capacity")

endmodule

FILE: dv/ald_line_checker.sv
// Checker for the ASCII line deframer: mirrors the line store and compares every result.
`timescale 1ns / 1ps

module ald_line_checker
  import ald_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_data_byte,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             out_strobe,
  input  logic             out_read_valid,
  input  logic [7:0]       out_read_byte,
  input  logic             out_last_of_line,
  input  logic [4:0]       out_lines_waiting,
  input  logic [2:0]       out_event_res,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_of_line;
    logic [4:0] lines_waiting;
    event_t     event_res;
  } line_result_t;

  // Mirror of the line store
  logic [7:0]  ring_mem [STORE_BYTES];
  int unsigned len_fifo [LINE_SLOTS];
  int unsigned wr_ptr;
  int unsigned commit_ptr;
  int unsigned rd_ptr;
  int unsigned fifo_head;
  int unsigned fifo_tail;
  int unsigned lines_held;
  int unsigned open_len;
  int unsigned rd_offset;
  int unsigned ring_fill;
  bit          skipping;
  int unsigned line_max;

  line_result_t expected_results[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  function automatic int unsigned active_limit();
    int unsigned m;
    m = line_max;
    if (m < 1) m = 1;
    if (m > LINE_LIMIT) m = LINE_LIMIT;
    return m;
  endfunction

  // Drop the open line and skip up to the next newline
  function automatic void drop_open_line();
    ring_fill = ring_fill - open_len;
    open_len  = 0;
    wr_ptr    = commit_ptr;
    skipping  = 1'b1;
  endfunction

  // Commit the first n bytes of the open line; fails when no length slot is free
  function automatic bit commit_open_line(int unsigned n);
    if (lines_held >= LINE_SLOTS) return 1'b0;
    len_fifo[fifo_tail] = n;
    fifo_tail  = (fifo_tail + 1) % LINE_SLOTS;
    lines_held = lines_held + 1;
    ring_fill  = ring_fill - (open_len - n);
    commit_ptr = (commit_ptr + n) % STORE_BYTES;
    wr_ptr     = commit_ptr;
    open_len   = 0;
    return 1'b1;
  endfunction

  function automatic event_t cut_open_line();
    if (!commit_open_line(active_limit())) begin
      drop_open_line();
      return EV_FULL;
    end
    skipping = 1'b1;
    return EV_TRUNC;
  endfunction

  function automatic event_t take_byte(logic [7:0] b);
    bit is_nl;
    bit is_print;
    is_nl    = (b == NL_LF) || (b == NL_CR);
    is_print = (b >= PRINT_LO) && (b <= PRINT_HI);
    // skip everything up to and including the next newline
    if (skipping) begin
      if (is_nl) skipping = 1'b0;
      return EV_NONE;
    end
    if (!is_nl && !is_print) begin
      drop_open_line();
      return EV_INVALID;
    end
    if (is_nl) begin
      if (open_len > active_limit()) return cut_open_line();
      if (open_len == 0) return EV_NONE;
      if (!commit_open_line(open_len)) begin
        drop_open_line();
        return EV_FULL;
      end
      return EV_DONE;
    end
    if (open_len >= active_limit()) return cut_open_line();
    if (ring_fill >= STORE_BYTES) begin
      drop_open_line();
      return EV_FULL;
    end
    ring_mem[wr_ptr] = b;
    wr_ptr    = (wr_ptr + 1) % STORE_BYTES;
    ring_fill = ring_fill + 1;
    open_len  = open_len + 1;
    return EV_NONE;
  endfunction

  function automatic line_result_t predict_line_result(op_t op, logic [7:0] b);
    line_result_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (op)
      OP_PUSH: r.event_res = take_byte(b);
      OP_READ: begin
        // hand out the next byte of the oldest stored line
        if (lines_held > 0) begin
          r.read_valid = 1'b1;
          r.read_byte  = ring_mem[rd_ptr];
          rd_ptr       = (rd_ptr + 1) % STORE_BYTES;
          if (ring_fill > 0) ring_fill = ring_fill - 1;
          rd_offset = rd_offset + 1;
          if (rd_offset >= len_fifo[fifo_head]) begin
            r.last_of_line = 1'b1;
            rd_offset      = 0;
            fifo_head      = (fifo_head + 1) % LINE_SLOTS;
            lines_held     = lines_held - 1;
          end
        end
      end
      OP_DISCARD: drop_open_line();
      default: ;
    endcase
    r.lines_waiting = 5'(lines_held);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] ald_line_checker: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin : watch_channels
    line_result_t want;
    if (!rst_n) begin
      wr_ptr     = 0;
      commit_ptr = 0;
      rd_ptr     = 0;
      fifo_head  = 0;
      fifo_tail  = 0;
      lines_held = 0;
      open_len   = 0;
      rd_offset  = 0;
      ring_fill  = 0;
      skipping   = 1'b0;
      line_max   = LINE_LIMIT;
      expected_results.delete();
    end else begin
      if (cfg_we) line_max = 32'(cfg_wdata);
      // compare the result shown this cycle with the oldest expectation
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 8'(out_event_res), 8'h00);
        end else begin
          want = expected_results.pop_front();
          check_field("read_valid", 8'(out_read_valid), 8'(want.read_valid));
          check_field("read_byte", out_read_byte, want.read_byte);
          check_field("last_of_line", 8'(out_last_of_line), 8'(want.last_of_line));
          check_field("lines_waiting", 8'(out_lines_waiting), 8'(want.lines_waiting));
          check_field("event_res", 8'(out_event_res), 8'(want.event_res));
        end
      end
      // predict the result of a request taken at this edge
      if (start && !busy)
        expected_results.push_back(predict_line_result(op_t'(in_operation), in_data_byte));
    end
    pending <= expected_results.size();
  end

endmodule

FILE: dv/tb_ascii_line_deframer_top.sv
// Testbench top for the ASCII line deframer: reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_ascii_line_deframer_top;
  import ald_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_operation;
  logic [7:0]       in_data_byte;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             out_strobe;
  logic             out_read_valid;
  logic [7:0]       out_read_byte;
  logic             out_last_of_line;
  logic [4:0]       out_lines_waiting;
  logic [2:0]       out_event_res;

  int fail_count;
  int pending;
  int cycles = 0;
  bit gaps_on;

  ascii_line_deframer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_read_valid    (out_read_valid),
    .out_read_byte     (out_read_byte),
    .out_last_of_line  (out_last_of_line),
    .out_lines_waiting (out_lines_waiting),
    .out_event_res     (out_event_res)
  );

  ald_line_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_read_valid    (out_read_valid),
    .out_read_byte     (out_read_byte),
    .out_last_of_line  (out_last_of_line),
    .out_lines_waiting (out_lines_waiting),
    .out_event_res     (out_event_res),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(0, 1) ? NL_LF : NL_CR;
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((b >= PRINT_LO && b <= PRINT_HI) || b == NL_LF || b == NL_CR)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Issue one request and hold it until the block takes it
  task automatic send_request(op_t op, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_printables(int n);
    repeat (n) send_request(OP_PUSH, printable_byte());
  endtask

  task automatic push_line(int n);
    push_printables(n);
    send_request(OP_PUSH, line_end());
  endtask

  task automatic read_bytes(int n);
    repeat (n) send_request(OP_READ, 8'($urandom_range(0, 255)));
  endtask

  // Hold off requests until every result is back, then let the block settle
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_max(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed lines and read bursts, with some noise mixed in
  task automatic run_mixed_traffic(int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(0, 14);
        push_line(len);
        sent += len + 1;
      end else if (pick < 85) begin
        len = $urandom_range(1, 16);
        read_bytes(len);
        sent += len;
      end else begin
        if (pick < 90)
          send_request(OP_PUSH, bad_byte());
        else if (pick < 93)
          send_request(OP_DISCARD, 8'($urandom_range(0, 255)));
        else if (pick < 96)
          send_request(OP_NOP, 8'($urandom_range(0, 255)));
        else
          send_request(op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_NOP;
    in_data_byte <= 8'h00;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Basic framing at the reset limit
    send_request(OP_READ, 8'hA5);      // nothing stored yet
    send_request(OP_NOP, 8'hFF);
    send_request(OP_PUSH, PRINT_LO);
    send_request(OP_PUSH, PRINT_HI);
    send_request(OP_PUSH, NL_LF);
    send_request(OP_PUSH, NL_CR);      // empty line, dropped
    send_request(OP_PUSH, 8'h41);
    send_request(OP_PUSH, 8'h1F);      // invalid byte kills the open line
    send_request(OP_PUSH, 8'h42);      // skipped during resync
    send_request(OP_PUSH, 8'hFF);      // skipped during resync
    send_request(OP_PUSH, NL_CR);      // ends resync
    send_request(OP_PUSH, 8'h7F);      // invalid on an empty line
    send_request(OP_PUSH, NL_LF);
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, NL_LF);
    send_request(OP_PUSH, 8'h80);
    send_request(OP_PUSH, NL_LF);
    send_request(OP_PUSH, 8'h78);
    send_request(OP_DISCARD, 8'h00);
    send_request(OP_PUSH, 8'h79);      // skipped after discard
    send_request(OP_PUSH, NL_LF);
    read_bytes(4);

    // Zero limit clamps to a single byte
    settle_idle();
    write_line_max('0);
    push_printables(2);
    send_request(OP_PUSH, NL_LF);
    push_line(1);
    read_bytes(3);

    // Lower the limit under an open line: printable byte, then newline
    settle_idle();
    write_line_max('1);
    push_printables(6);
    settle_idle();
    write_line_max(13'd3);
    send_request(OP_PUSH, printable_byte());
    send_request(OP_PUSH, NL_LF);
    settle_idle();
    write_line_max('1);
    push_printables(6);
    settle_idle();
    write_line_max(13'd2);
    send_request(OP_PUSH, NL_CR);
    send_request(OP_PUSH, NL_LF);
    read_bytes(8);

    // Run out of length slots
    settle_idle();
    write_line_max(13'd4);
    repeat (18) push_line(1);
    read_bytes(40);

    // Random traffic over several limits
    settle_idle();
    write_line_max(13'd1);
    run_mixed_traffic(130);
    settle_idle();
    write_line_max(13'd5);
    run_mixed_traffic(130);
    settle_idle();
    write_line_max(13'($urandom_range(6, 14)));
    run_mixed_traffic(130);
    settle_idle();
    write_line_max(13'($urandom_range(0, 8191)));
    run_mixed_traffic(130);
    settle_idle();
    write_line_max(13'd8);
    gaps_on = 1'b0;
    run_mixed_traffic(150);

    settle_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
